@@ src/yrgb_pkg.sv @@
// Shared constants and types for the YUYV to RGB converter.
// Holds the fixed-point coefficients, datapath widths and the structs passed between modules.
`timescale 1ns / 1ps

package yrgb_pkg;

  localparam int PIX_W    = 8;
  localparam int GAIN_W   = 9;
  localparam int FRAC_W   = 16;
  localparam int CHROMA_W = 26;
  localparam int SUM_W    = 27;
  localparam int PROD_W   = PIX_W + GAIN_W;

  localparam logic signed [17:0] COEF_R_V = 18'sd89830;
  localparam logic signed [17:0] COEF_G_V = 18'sd45744;
  localparam logic signed [17:0] COEF_G_U = 18'sd22127;
  localparam logic signed [17:0] COEF_B_U = 18'sd113538;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd220;

  typedef struct packed {
    logic signed [CHROMA_W-1:0] cr;
    logic signed [CHROMA_W-1:0] cgv;
    logic signed [CHROMA_W-1:0] cgu;
    logic signed [CHROMA_W-1:0] cb;
  } chroma_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

endpackage

@@ src/yrgb_chroma.sv @@
// Shared chroma stage: forms the four coefficient products from one U/V pair.
// Depends on yrgb_pkg for the coefficients and the chroma_t struct.
`timescale 1ns / 1ps

module yrgb_chroma (
  input  logic                      clk,
  input  logic                      en,
  input  logic [yrgb_pkg::PIX_W-1:0] chroma_blue,
  input  logic [yrgb_pkg::PIX_W-1:0] chroma_red,
  output yrgb_pkg::chroma_t          terms
);

  logic signed [yrgb_pkg::PIX_W-1:0] du;
  logic signed [yrgb_pkg::PIX_W-1:0] dv;

  // Removing the offset of 128 from an 8-bit sample is a flip of its top bit.
  assign du = {~chroma_blue[yrgb_pkg::PIX_W-1], chroma_blue[yrgb_pkg::PIX_W-2:0]};
  assign dv = {~chroma_red[yrgb_pkg::PIX_W-1], chroma_red[yrgb_pkg::PIX_W-2:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      terms.cr  <= yrgb_pkg::CHROMA_W'(yrgb_pkg::COEF_R_V) * yrgb_pkg::CHROMA_W'(dv);
      terms.cgv <= yrgb_pkg::CHROMA_W'(yrgb_pkg::COEF_G_V) * yrgb_pkg::CHROMA_W'(dv);
      terms.cgu <= yrgb_pkg::CHROMA_W'(yrgb_pkg::COEF_G_U) * yrgb_pkg::CHROMA_W'(du);
      terms.cb  <= yrgb_pkg::CHROMA_W'(yrgb_pkg::COEF_B_U) * yrgb_pkg::CHROMA_W'(du);
    end
  end

endmodule

@@ src/yrgb_lane.sv @@
// One pixel lane: adds luma to the chroma terms, clamps, then applies the output gain.
// Depends on yrgb_pkg for widths and the chroma_t and rgb_t structs.
`timescale 1ns / 1ps

module yrgb_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [yrgb_pkg::PIX_W-1:0]  luma,
  input  yrgb_pkg::chroma_t           terms,
  input  logic [yrgb_pkg::GAIN_W-1:0] gain,
  output yrgb_pkg::rgb_t              pixel
);

  logic signed [yrgb_pkg::SUM_W-1:0] base;
  logic signed [yrgb_pkg::SUM_W-1:0] sum_r;
  logic signed [yrgb_pkg::SUM_W-1:0] sum_g;
  logic signed [yrgb_pkg::SUM_W-1:0] sum_b;
  yrgb_pkg::rgb_t                    clamped;

  function automatic logic [yrgb_pkg::PIX_W-1:0] clamp(
    input logic signed [yrgb_pkg::SUM_W-1:0] s
  );
    logic [yrgb_pkg::PIX_W-1:0] c;
    if (s[yrgb_pkg::SUM_W-1]) begin
      c = '0;
    end else if (|s[yrgb_pkg::SUM_W-2:yrgb_pkg::FRAC_W+yrgb_pkg::PIX_W]) begin
      c = '1;
    end else begin
      c = s[yrgb_pkg::FRAC_W+yrgb_pkg::PIX_W-1:yrgb_pkg::FRAC_W];
    end
    return c;
  endfunction

  function automatic logic [yrgb_pkg::PIX_W-1:0] scale(
    input logic [yrgb_pkg::PIX_W-1:0]  c,
    input logic [yrgb_pkg::GAIN_W-1:0] g
  );
    logic [yrgb_pkg::PROD_W-1:0] p;
    p = yrgb_pkg::PROD_W'(c) * yrgb_pkg::PROD_W'(g);
    return p[yrgb_pkg::PROD_W-1] ? '1 : p[yrgb_pkg::PROD_W-2:yrgb_pkg::PIX_W];
  endfunction

  assign base  = $signed({{(yrgb_pkg::SUM_W-yrgb_pkg::PIX_W-yrgb_pkg::FRAC_W){1'b0}},
                          luma, {yrgb_pkg::FRAC_W{1'b0}}});
  assign sum_r = base + yrgb_pkg::SUM_W'(terms.cr);
  assign sum_g = base - yrgb_pkg::SUM_W'(terms.cgv) - yrgb_pkg::SUM_W'(terms.cgu);
  assign sum_b = base + yrgb_pkg::SUM_W'(terms.cb);

  always_ff @(posedge clk) begin
    if (en) begin
      clamped.red   <= clamp(sum_r);
      clamped.green <= clamp(sum_g);
      clamped.blue  <= clamp(sum_b);
      pixel.red     <= scale(clamped.red, gain);
      pixel.green   <= scale(clamped.green, gain);
      pixel.blue    <= scale(clamped.blue, gain);
    end
  end

endmodule

@@ src/yuyv_to_rgb_scaled_converter.sv @@
// Top level of the YUYV 4:2:2 to RGB888 converter with output gain.
// Depends on yrgb_pkg, yrgb_chroma and yrgb_lane.
`timescale 1ns / 1ps

// Each transfer on the slave side carries one YUYV macropixel and produces one transfer on
// the master side with two RGB pixels that share its chroma. The block takes one macropixel
// every cycle while not stalled and is pipelined: a shared chroma multiply stage, then two
// pixel lanes that each add luma and clamp in one stage and apply the gain in the next, whose
// registers also hold the result. The whole pipeline stalls while a result waits to be taken.
// The gain register resets to 220 and is meant to be written only while no data is in flight.

module yuyv_to_rgb_scaled_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // luma_first, chroma_blue, luma_second, chroma_red
  input  logic [31:0] s_tdata,
  // frame_end
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // red_first, green_first, blue_first, red_second, green_second, blue_second
  output logic [47:0] m_tdata,
  // frame_end_out
  output logic        m_tlast,
  input  logic        gain_wr_en,
  input  logic [8:0]  gain_wr_data
);

  logic                        en;
  logic [yrgb_pkg::GAIN_W-1:0] gain;
  logic                        valid_mul;
  logic                        valid_clamp;
  logic [yrgb_pkg::PIX_W-1:0]  luma_first;
  logic [yrgb_pkg::PIX_W-1:0]  luma_second;
  logic                        last_mul;
  logic                        last_clamp;
  yrgb_pkg::chroma_t           terms;
  yrgb_pkg::rgb_t              pixel_first;
  yrgb_pkg::rgb_t              pixel_second;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain        <= yrgb_pkg::GAIN_RESET;
      valid_mul   <= 1'b0;
      valid_clamp <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (gain_wr_en) begin
        gain <= gain_wr_data;
      end
      if (en) begin
        valid_mul   <= s_tvalid;
        valid_clamp <= valid_mul;
        m_tvalid    <= valid_clamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      luma_first  <= s_tdata[7:0];
      luma_second <= s_tdata[23:16];
      last_mul    <= s_tlast;
      last_clamp  <= last_mul;
      m_tlast     <= last_clamp;
    end
  end

  yrgb_chroma u_chroma (
    .clk         (clk),
    .en          (en),
    .chroma_blue (s_tdata[15:8]),
    .chroma_red  (s_tdata[31:24]),
    .terms       (terms)
  );

  yrgb_lane u_lane_first (
    .clk   (clk),
    .en    (en),
    .luma  (luma_first),
    .terms (terms),
    .gain  (gain),
    .pixel (pixel_first)
  );

  yrgb_lane u_lane_second (
    .clk   (clk),
    .en    (en),
    .luma  (luma_second),
    .terms (terms),
    .gain  (gain),
    .pixel (pixel_second)
  );

  assign m_tdata = {pixel_second.blue, pixel_second.green, pixel_second.red,
                    pixel_first.blue, pixel_first.green, pixel_first.red};

endmodule
